>>> sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Action codes, character codes, controller states, item and result records.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_BACK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ERASE   = 8'h08;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] BLANK_ATTR = 8'h0F;

  typedef struct packed {
    action_t     action;
    logic [7:0]  char_code;
    logic [3:0]  fore_color;
    logic [3:0]  back_color;
    logic        use_position;
    logic [6:0]  col_in;
    logic [4:0]  row_in;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_attr;
    logic [7:0]  read_char;
    logic [10:0] cursor_cell;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } result_t;

endpackage

>>> sv/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram: screen cell store
// One write port, one read port with registered read data. Cell is
// {attribute, character}.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: console sequencer
// Decodes an item, updates the cursor, and runs the shared address counter
// over the cell store for clear, scroll, last-row zeroing and reset fill.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int AW   = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  tcw_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output tcw_pkg::result_t res,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [15:0]      ram_wdata,
  output logic             ram_re,
  output logic [AW-1:0]    ram_raddr,
  input  logic [15:0]      ram_rdata
);

  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW0 = AW'(CELLS - COLS);

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic          pend_r, pend_nxt;
  logic          clr_mode_r, clr_mode_nxt;
  logic          resp_pend_r, resp_pend_nxt;
  logic          rd_hit_r, rd_hit_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [31:0] cur_pos;
  logic [31:0] b_col, b_row, n_col, n_row;
  logic [31:0] bs_col, bs_row;
  logic [31:0] put_addr, bs_addr, rd_addr;
  logic        in_rng, put_scroll;
  logic [7:0]  put_char;
  logic [15:0] sweep_data;

  // item decode: target cell and new cursor for put, backspace and read
  always_comb begin
    cur_pos = 32'(row_r) * COLS + 32'(col_r);
    in_rng  = (32'(item.col_in) < COLS) && (32'(item.row_in) < ROWS);
    if (item.use_position && in_rng) begin
      b_col = 32'(item.col_in);
      b_row = 32'(item.row_in);
    end else begin
      b_col = 32'(col_r);
      b_row = 32'(row_r);
    end
    n_col = b_col;
    n_row = b_row;
    if (item.char_code == CH_NEWLINE) begin
      n_col = 32'd0;
      n_row = b_row + 32'd1;
    end else if (item.char_code != CH_ERASE) begin
      n_col = b_col + 32'd1;
      if (n_col == COLS) begin
        n_col = 32'd0;
        n_row = b_row + 32'd1;
      end
    end
    put_scroll = (n_row == ROWS);
    if (put_scroll) begin
      n_row = 32'(ROWS - 1);
    end
    put_char = (item.char_code == CH_ERASE) ? CH_SPACE : item.char_code;
    put_addr = b_row * COLS + b_col;

    bs_col = 32'(col_r);
    bs_row = 32'(row_r);
    if (cur_pos != 32'd0) begin
      if (col_r == '0) begin
        bs_col = 32'(COLS - 1);
        bs_row = 32'(row_r) - 32'd1;
      end else begin
        bs_col = 32'(col_r) - 32'd1;
      end
    end
    bs_addr = bs_row * COLS + bs_col;
    rd_addr = 32'(item.row_in) * COLS + 32'(item.col_in);
  end

  assign sweep_data = clr_mode_r ? {ram_rdata[15:8], CH_SPACE} : ram_rdata;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          case (item.action)
            ACT_PUT:   state_nxt = put_scroll ? ST_SWEEP : ST_DONE;
            ACT_CLEAR: state_nxt = ST_SWEEP;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (cnt_r == LAST_CELL) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = clr_mode_r ? ST_DONE : ST_FILL;
      ST_FILL: begin
        if (cnt_r == LAST_CELL) state_nxt = resp_pend_r ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    item_ready    = (state_r == ST_IDLE);
    res_valid     = (state_r == ST_DONE);
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = cnt_r;
    cnt_nxt       = cnt_r;
    wr_addr_nxt   = wr_addr_r;
    pend_nxt      = pend_r;
    clr_mode_nxt  = clr_mode_r;
    resp_pend_nxt = resp_pend_r;
    rd_hit_nxt    = rd_hit_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          resp_pend_nxt = 1'b1;
          rd_hit_nxt    = 1'b0;
          case (item.action)
            ACT_PUT: begin
              ram_we       = (item.char_code != CH_NEWLINE);
              ram_waddr    = put_addr[AW-1:0];
              ram_wdata    = {item.back_color, item.fore_color, put_char};
              col_nxt      = n_col[CW-1:0];
              row_nxt      = n_row[RW-1:0];
              cnt_nxt      = AW'(COLS);
              clr_mode_nxt = 1'b0;
            end
            ACT_BACK: begin
              ram_we    = 1'b1;
              ram_waddr = bs_addr[AW-1:0];
              ram_wdata = {BLANK_ATTR, CH_SPACE};
              col_nxt   = bs_col[CW-1:0];
              row_nxt   = bs_row[RW-1:0];
            end
            ACT_CLEAR: begin
              col_nxt      = '0;
              row_nxt      = '0;
              cnt_nxt      = '0;
              clr_mode_nxt = 1'b1;
            end
            ACT_READ: begin
              ram_re     = in_rng;
              ram_raddr  = rd_addr[AW-1:0];
              rd_hit_nxt = in_rng;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        // read one cell per cycle; put the prior one in place or a row up
        ram_re      = 1'b1;
        ram_raddr   = cnt_r;
        pend_nxt    = 1'b1;
        wr_addr_nxt = clr_mode_r ? cnt_r : cnt_r - AW'(COLS);
        ram_we      = pend_r;
        ram_waddr   = wr_addr_r;
        ram_wdata   = sweep_data;
        cnt_nxt     = (cnt_r == LAST_CELL) ? LAST_ROW0 : cnt_r + AW'(1);
      end
      ST_DRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr_r;
        ram_wdata = sweep_data;
        pend_nxt  = 1'b0;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        if (cnt_r != LAST_CELL) cnt_nxt = cnt_r + AW'(1);
      end
      ST_DONE: begin
        if (res_ready) resp_pend_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.cursor_col  = 7'(col_r);
    res.cursor_row  = 5'(row_r);
    res.cursor_cell = cur_pos[10:0];
    res.read_char   = rd_hit_r ? ram_rdata[7:0]  : 8'h00;
    res.read_attr   = rd_hit_r ? ram_rdata[15:8] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      clr_mode_r  <= 1'b0;
      resp_pend_r <= 1'b0;
      rd_hit_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      clr_mode_r  <= clr_mode_nxt;
      resp_pend_r <= resp_pend_nxt;
      rd_hit_r    <= rd_hit_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
  end

endmodule

>>> sv/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  in_tdata[31:0], in_tuser[1:0] = action
//   out_     out  out_tvalid/out_tready out_tdata[39:0]
//
// Put, backspace and read: the item is accepted, then the result is offered.
// A put that scrolls copies each row of the store up one, then zeroes the
// last row; clear blanks every character and keeps its attribute. After
// reset a fill pass zeroes the store; in_tready stays low until it ends.
// One transaction is in work at a time; a finished result waits in the
// output register while the next one is accepted.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], fore_color[11:8], back_color[15:12], use_position[16],
  // col_in[23:17], row_in[28:24], zero[31:29]
  input  logic [31:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cursor_col[6:0], cursor_row[11:7], cursor_cell[22:12], read_char[30:23],
  // read_attr[38:31], zero[39]
  output logic [39:0] out_tdata
);

  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  item_t         item;
  result_t       res;
  logic          res_valid, res_ready;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic          out_valid_r, out_valid_nxt;
  result_t       out_data_r;

  always_comb begin
    item.action       = action_t'(in_tuser);
    item.char_code    = in_tdata[7:0];
    item.fore_color   = in_tdata[11:8];
    item.back_color   = in_tdata[15:12];
    item.use_position = in_tdata[16];
    item.col_in       = in_tdata[23:17];
    item.row_in       = in_tdata[28:24];
  end

  tcw_ctrl #(
    .COLS(COLS),
    .ROWS(ROWS),
    .AW  (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_tvalid),
    .item_ready(in_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule
